@@ src/calendar_clock_counter_defines.svh @@
// Assertion macros for the calendar clock counter.
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define CCC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition leads to a consequence in the next cycle.
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCC_ASSERT_ALWAYS(label, expr, msg)
`define CCC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/ccc_pkg.sv @@
// Shared types, constants and the month length table for the calendar clock counter.
package ccc_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int WEEKDAY_W = 3;
    localparam int MASK_W    = 6;

    localparam logic [YEAR_W-1:0]    YEAR_MAX      = 14'd9999;
    localparam logic [YEAR_W-1:0]    RESET_YEAR    = 14'd1900;
    localparam logic [MONTH_W-1:0]   MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0]   MONTH_LAST    = 4'd12;
    localparam logic [DAY_W-1:0]     DAY_FIRST     = 5'd1;
    localparam logic [HOUR_W-1:0]    HOUR_LAST     = 5'd23;
    localparam logic [MINUTE_W-1:0]  MINUTE_LAST   = 6'd59;
    localparam logic [SECOND_W-1:0]  SECOND_LAST   = 6'd59;
    localparam logic [WEEKDAY_W-1:0] WEEKDAY_LAST  = 3'd6;
    localparam logic [WEEKDAY_W-1:0] RESET_WEEKDAY = 3'd1;

    localparam logic [DAY_W-1:0] DAYS_LONG  = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB   = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_LEAP  = 5'd29;

    // Bit positions in the rollover mask.
    localparam int MASK_SECOND = 0;
    localparam int MASK_MINUTE = 1;
    localparam int MASK_HOUR   = 2;
    localparam int MASK_DAY    = 3;
    localparam int MASK_MONTH  = 4;
    localparam int MASK_YEAR   = 5;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [SECOND_W-1:0]  second;
        logic [WEEKDAY_W-1:0] weekday;
    } time_t;

    typedef struct packed {
        cmd_t  command;
        time_t load_time;
    } in_word_t;

    typedef struct packed {
        time_t             time_next;
        logic [MASK_W-1:0] mask;
        logic              rejected;
    } step_t;

    // Any month outside the 31 and 30 day lists counts as February.
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return DAYS_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    return DAYS_SHORT;
            default: return (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
        endcase
    endfunction

endpackage

@@ src/ccc_in_stage.sv @@
// Input register stage: hold one accepted word until the step logic takes it.
module ccc_in_stage
    import ccc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     advance,
    output logic     word_valid,
    output in_word_t word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || advance;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

@@ src/ccc_step.sv @@
// Next-time logic: one-second carry chain and load validity check.
module ccc_step
    import ccc_pkg::*;
(
    input  in_word_t          word,
    input  time_t             time_now,
    input  logic [YEAR_W-1:0] min_year,
    output step_t             step
);

    always_comb
    begin
        time_t             t;
        time_t             ld;
        logic [MASK_W-1:0] mask;
        logic              load_ok;

        t       = time_now;
        ld      = word.load_time;
        mask    = '0;
        load_ok = 1'b0;

        if (word.command == CMD_TICK)
        begin
            // Compare against the last value so the increment never wraps.
            mask[MASK_SECOND] = 1'b1;
            if (t.second >= SECOND_LAST)
            begin
                t.second          = '0;
                mask[MASK_MINUTE] = 1'b1;
                if (t.minute >= MINUTE_LAST)
                begin
                    t.minute        = '0;
                    mask[MASK_HOUR] = 1'b1;
                    if (t.hour >= HOUR_LAST)
                    begin
                        t.hour         = '0;
                        mask[MASK_DAY] = 1'b1;
                        t.weekday      = (t.weekday >= WEEKDAY_LAST) ? '0 : t.weekday + 1'b1;
                        if (t.day >= month_length(t.month, t.year))
                        begin
                            t.day            = DAY_FIRST;
                            mask[MASK_MONTH] = 1'b1;
                            if (t.month >= MONTH_LAST)
                            begin
                                t.month = MONTH_FIRST;
                                if (t.year < YEAR_MAX)
                                begin
                                    t.year          = t.year + 1'b1;
                                    mask[MASK_YEAR] = 1'b1;
                                end
                            end
                            else
                            begin
                                t.month = t.month + 1'b1;
                            end
                        end
                        else
                        begin
                            t.day = t.day + 1'b1;
                        end
                    end
                    else
                    begin
                        t.hour = t.hour + 1'b1;
                    end
                end
                else
                begin
                    t.minute = t.minute + 1'b1;
                end
            end
            else
            begin
                t.second = t.second + 1'b1;
            end
        end
        else
        begin
            load_ok = (ld.year >= min_year) && (ld.year <= YEAR_MAX)
                   && (ld.month >= MONTH_FIRST) && (ld.month <= MONTH_LAST)
                   && (ld.day >= DAY_FIRST) && (ld.day <= month_length(ld.month, ld.year))
                   && (ld.hour <= HOUR_LAST) && (ld.minute <= MINUTE_LAST)
                   && (ld.second <= SECOND_LAST) && (ld.weekday <= WEEKDAY_LAST);
            if (load_ok)
            begin
                t = ld;
            end
        end

        step.time_next = t;
        step.mask      = mask;
        step.rejected  = (word.command == CMD_LOAD) && !load_ok;
    end

endmodule

@@ src/calendar_clock_counter.sv @@
// Calendar clock counter top level: time registers, result register and handshakes.
//
// Usage: each word on the input channel (in_valid / in_ready) is either a
// one-second tick (command 0) or a load of the full time from the new_*
// fields (command 1). Every word yields exactly one result word on the
// output channel (out_valid / out_ready): the time after the step, the
// rollover mask of the fields a tick changed, and load_rejected for a load
// that failed the range check (year below min_year or above 9999, bad
// month, day beyond the month, hour, minute, second or weekday too large).
// A word accepted on the input channel waits in the input register, passes
// through the step logic and is captured in the result register, which sets
// out_valid. Throughput: one word per cycle while out_ready stays high;
// the carry chain from seconds to years is a single pass of logic between
// the input register and the result register.
// min_year is written through min_year_we / min_year_wdata while idle.
// Reset: time goes to 1900-01-01 00:00:00, Monday; min_year to 1900; both
// channels empty. A stalled receiver holds the result register, the input
// register then fills and in_ready drops until out_ready returns.
`include "calendar_clock_counter_defines.svh"

module calendar_clock_counter
    import ccc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 min_year_we,
    input  logic [YEAR_W-1:0]    min_year_wdata,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [YEAR_W-1:0]    new_year,
    input  logic [MONTH_W-1:0]   new_month,
    input  logic [DAY_W-1:0]     new_day,
    input  logic [HOUR_W-1:0]    new_hour,
    input  logic [MINUTE_W-1:0]  new_minute,
    input  logic [SECOND_W-1:0]  new_second,
    input  logic [WEEKDAY_W-1:0] new_weekday,
    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [YEAR_W-1:0]    year,
    output logic [MONTH_W-1:0]   month,
    output logic [DAY_W-1:0]     day,
    output logic [HOUR_W-1:0]    hour,
    output logic [MINUTE_W-1:0]  minute,
    output logic [SECOND_W-1:0]  second,
    output logic [WEEKDAY_W-1:0] weekday,
    output logic [MASK_W-1:0]    rollover_mask,
    output logic                 load_rejected
);

    in_word_t          in_word;
    in_word_t          word;
    logic              word_valid;
    logic              advance;
    step_t             step;

    logic [YEAR_W-1:0] min_year_reg;
    time_t             time_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    step_t             result_reg;

    // Pack the input fields into one word.
    assign in_word.command             = cmd_t'(command);
    assign in_word.load_time.year      = new_year;
    assign in_word.load_time.month     = new_month;
    assign in_word.load_time.day       = new_day;
    assign in_word.load_time.hour      = new_hour;
    assign in_word.load_time.minute    = new_minute;
    assign in_word.load_time.second    = new_second;
    assign in_word.load_time.weekday   = new_weekday;

    ccc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .advance    (advance),
        .word_valid (word_valid),
        .word       (word)
    );

    ccc_step u_step (
        .word     (word),
        .time_now (time_reg),
        .min_year (min_year_reg),
        .step     (step)
    );

    // Move the held word on whenever the result register is free or draining.
    assign advance = word_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the configuration and the running time; update time as each word passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg     <= RESET_YEAR;
            time_reg.year    <= RESET_YEAR;
            time_reg.month   <= MONTH_FIRST;
            time_reg.day     <= DAY_FIRST;
            time_reg.hour    <= '0;
            time_reg.minute  <= '0;
            time_reg.second  <= '0;
            time_reg.weekday <= RESET_WEEKDAY;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (min_year_we)
            begin
                min_year_reg <= min_year_wdata;
            end
            if (advance)
            begin
                time_reg <= step.time_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset; capture it with the time update.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step;
        end
    end

    assign out_valid     = out_valid_reg;
    assign year          = result_reg.time_next.year;
    assign month         = result_reg.time_next.month;
    assign day           = result_reg.time_next.day;
    assign hour          = result_reg.time_next.hour;
    assign minute        = result_reg.time_next.minute;
    assign second        = result_reg.time_next.second;
    assign weekday       = result_reg.time_next.weekday;
    assign rollover_mask = result_reg.mask;
    assign load_rejected = result_reg.rejected;

    // A passing word must land in the result register.
    `CCC_ASSERT_NEXT(a_advance_fills, advance, out_valid_reg, "word lost on advance")
    // A refused load never reports rollover.
    `CCC_ASSERT_ALWAYS(a_reject_no_mask,
        !(out_valid_reg && result_reg.rejected && (result_reg.mask != '0)),
        "rejected load with rollover mask")
    // The mask is empty or a run of ones starting at the second.
    `CCC_ASSERT_ALWAYS(a_mask_chain,
        !out_valid_reg || ((result_reg.mask & (result_reg.mask + 6'd1)) == '0),
        "broken rollover chain")
    // The running time stays in range.
    `CCC_ASSERT_ALWAYS(a_time_range,
        (time_reg.second <= SECOND_LAST) && (time_reg.minute <= MINUTE_LAST)
            && (time_reg.hour <= HOUR_LAST) && (time_reg.weekday <= WEEKDAY_LAST)
            && (time_reg.year <= YEAR_MAX),
        "time field out of range")

endmodule

@@ sim/calendar_clock_counter_checker.sv @@
// Checker for the calendar clock counter: predicts every result word and compares it.
`timescale 1ns / 1ps

module calendar_clock_counter_checker
    import ccc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 min_year_we,
    input  logic [YEAR_W-1:0]    min_year_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 command,
    input  logic [YEAR_W-1:0]    new_year,
    input  logic [MONTH_W-1:0]   new_month,
    input  logic [DAY_W-1:0]     new_day,
    input  logic [HOUR_W-1:0]    new_hour,
    input  logic [MINUTE_W-1:0]  new_minute,
    input  logic [SECOND_W-1:0]  new_second,
    input  logic [WEEKDAY_W-1:0] new_weekday,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [YEAR_W-1:0]    year,
    input  logic [MONTH_W-1:0]   month,
    input  logic [DAY_W-1:0]     day,
    input  logic [HOUR_W-1:0]    hour,
    input  logic [MINUTE_W-1:0]  minute,
    input  logic [SECOND_W-1:0]  second,
    input  logic [WEEKDAY_W-1:0] weekday,
    input  logic [MASK_W-1:0]    rollover_mask,
    input  logic                 load_rejected,
    output int                   mismatches,
    output int                   readings_due
);

    time_t             calendar;
    logic [YEAR_W-1:0] earliest_year;
    step_t             predicted_readings[$];
    int                error_total;

    // Months off both lists count as February.
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
            return 5'd30;
        if (m == 4'd1 || m == 4'd3 || m == 4'd5 || m == 4'd7 || m == 4'd8 ||
            m == 4'd10 || m == 4'd12)
            return 5'd31;
        return (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
    endfunction

    function automatic bit load_fits(input time_t t);
        if (t.year < earliest_year || t.year > 14'd9999) return 1'b0;
        if (t.month < 4'd1 || t.month > 4'd12) return 1'b0;
        if (t.day < 5'd1 || t.day > days_in(t.month, t.year)) return 1'b0;
        if (t.hour > 5'd23 || t.minute > 6'd59 || t.second > 6'd59) return 1'b0;
        return t.weekday <= 3'd6;
    endfunction

    task automatic advance_calendar(input in_word_t w, output step_t r);
        r.mask     = '0;
        r.rejected = 1'b0;
        if (w.command == CMD_TICK)
        begin
            r.mask[MASK_SECOND] = 1'b1;
            if (calendar.second >= 6'd59)
            begin
                calendar.second = '0;
                r.mask[MASK_MINUTE] = 1'b1;
                if (calendar.minute >= 6'd59)
                begin
                    calendar.minute = '0;
                    r.mask[MASK_HOUR] = 1'b1;
                    if (calendar.hour >= 5'd23)
                    begin
                        calendar.hour = '0;
                        r.mask[MASK_DAY] = 1'b1;
                        calendar.weekday = (calendar.weekday >= 3'd6) ? 3'd0
                                                                      : calendar.weekday + 3'd1;
                        if (calendar.day >= days_in(calendar.month, calendar.year))
                        begin
                            calendar.day = 5'd1;
                            r.mask[MASK_MONTH] = 1'b1;
                            if (calendar.month >= 4'd12)
                            begin
                                calendar.month = 4'd1;
                                // hold the year at its ceiling
                                if (calendar.year < 14'd9999)
                                begin
                                    calendar.year = calendar.year + 14'd1;
                                    r.mask[MASK_YEAR] = 1'b1;
                                end
                            end
                            else
                            begin
                                calendar.month = calendar.month + 4'd1;
                            end
                        end
                        else
                        begin
                            calendar.day = calendar.day + 5'd1;
                        end
                    end
                    else
                    begin
                        calendar.hour = calendar.hour + 5'd1;
                    end
                end
                else
                begin
                    calendar.minute = calendar.minute + 6'd1;
                end
            end
            else
            begin
                calendar.second = calendar.second + 6'd1;
            end
        end
        else if (load_fits(w.load_time))
        begin
            calendar = w.load_time;
        end
        else
        begin
            r.rejected = 1'b1;
        end
        r.time_next = calendar;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        in_word_t seen;
        step_t    due;
        if (!rst_n)
        begin
            calendar.year    = 14'd1900;
            calendar.month   = 4'd1;
            calendar.day     = 5'd1;
            calendar.hour    = '0;
            calendar.minute  = '0;
            calendar.second  = '0;
            calendar.weekday = 3'd1;
            earliest_year    = 14'd1900;
            predicted_readings.delete();
            error_total  = 0;
            mismatches   <= 0;
            readings_due <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (predicted_readings.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %0d-%0d-%0d",
                             $time, year, month, day);
                    error_total++;
                end
                else
                begin
                    due = predicted_readings.pop_front();
                    check_field("year", 32'(due.time_next.year), 32'(year));
                    check_field("month", 32'(due.time_next.month), 32'(month));
                    check_field("day", 32'(due.time_next.day), 32'(day));
                    check_field("hour", 32'(due.time_next.hour), 32'(hour));
                    check_field("minute", 32'(due.time_next.minute), 32'(minute));
                    check_field("second", 32'(due.time_next.second), 32'(second));
                    check_field("weekday", 32'(due.time_next.weekday), 32'(weekday));
                    check_field("rollover_mask", 32'(due.mask), 32'(rollover_mask));
                    check_field("load_rejected", 32'(due.rejected), 32'(load_rejected));
                end
            end
            if (min_year_we === 1'b1)
                earliest_year = min_year_wdata;
            if (in_valid === 1'b1 && in_ready === 1'b1)
            begin
                seen.command           = cmd_t'(command);
                seen.load_time.year    = new_year;
                seen.load_time.month   = new_month;
                seen.load_time.day     = new_day;
                seen.load_time.hour    = new_hour;
                seen.load_time.minute  = new_minute;
                seen.load_time.second  = new_second;
                seen.load_time.weekday = new_weekday;
                advance_calendar(seen, due);
                predicted_readings.push_back(due);
            end
            mismatches   <= error_total;
            readings_due <= predicted_readings.size();
        end
    end

endmodule

@@ sim/tb_calendar_clock_counter.sv @@
// Testbench top for the calendar clock counter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_calendar_clock_counter;
    import ccc_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 min_year_we;
    logic [YEAR_W-1:0]    min_year_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_ready;
    in_word_t             stim_word;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [SECOND_W-1:0]  second;
    logic [WEEKDAY_W-1:0] weekday;
    logic [MASK_W-1:0]    rollover_mask;
    logic                 load_rejected;
    int                   mismatches;
    int                   readings_due;

    // Current min_year setting, so loads can aim at the accepted range.
    logic [YEAR_W-1:0]    floor_year;
    // When set, the side runs back to back with no idle cycles.
    bit                   feed_steady;
    bit                   drain_steady;

    localparam int PHASE_WORDS = 425;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    calendar_clock_counter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_year_we    (min_year_we),
        .min_year_wdata (min_year_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (stim_word.command),
        .new_year       (stim_word.load_time.year),
        .new_month      (stim_word.load_time.month),
        .new_day        (stim_word.load_time.day),
        .new_hour       (stim_word.load_time.hour),
        .new_minute     (stim_word.load_time.minute),
        .new_second     (stim_word.load_time.second),
        .new_weekday    (stim_word.load_time.weekday),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .year           (year),
        .month          (month),
        .day            (day),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .weekday        (weekday),
        .rollover_mask  (rollover_mask),
        .load_rejected  (load_rejected)
    );

    calendar_clock_counter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_year_we    (min_year_we),
        .min_year_wdata (min_year_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (stim_word.command),
        .new_year       (stim_word.load_time.year),
        .new_month      (stim_word.load_time.month),
        .new_day        (stim_word.load_time.day),
        .new_hour       (stim_word.load_time.hour),
        .new_minute     (stim_word.load_time.minute),
        .new_second     (stim_word.load_time.second),
        .new_weekday    (stim_word.load_time.weekday),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .year           (year),
        .month          (month),
        .day            (day),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .weekday        (weekday),
        .rollover_mask  (rollover_mask),
        .load_rejected  (load_rejected),
        .mismatches     (mismatches),
        .readings_due   (readings_due)
    );

    // Tick word; the load fields are random since the block must ignore them.
    function automatic in_word_t tick_word();
        in_word_t   w;
        logic [63:0] raw;
        raw       = {$urandom, $urandom};
        w         = raw[$bits(in_word_t)-1:0];
        w.command = CMD_TICK;
        return w;
    endfunction

    // Load word with every field drawn over its full width: mostly refused.
    function automatic in_word_t noise_load();
        in_word_t w;
        w         = tick_word();
        w.command = CMD_LOAD;
        return w;
    endfunction

    function automatic in_word_t load_word(int y, int mo, int d, int h, int mi, int s,
                                           int wd);
        in_word_t w;
        w.command           = CMD_LOAD;
        w.load_time.year    = YEAR_W'(y);
        w.load_time.month   = MONTH_W'(mo);
        w.load_time.day     = DAY_W'(d);
        w.load_time.hour    = HOUR_W'(h);
        w.load_time.minute  = MINUTE_W'(mi);
        w.load_time.second  = SECOND_W'(s);
        w.load_time.weekday = WEEKDAY_W'(wd);
        return w;
    endfunction

    // Load aimed at the carry boundaries: late seconds, last minute and hour,
    // month ends, December, February and the edges of the year range.
    function automatic in_word_t boundary_load();
        int y;
        int mo;
        int d;
        case ($urandom_range(0, 3))
            0:       y = 9999;
            1:       y = int'(floor_year);
            default: y = $urandom_range(9999, int'(floor_year));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: mo = 12;
            3, 4:    mo = 2;
            default: mo = $urandom_range(1, 12);
        endcase
        d = ($urandom_range(0, 1) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 28);
        return load_word(y, mo, d,
                         ($urandom_range(0, 1) == 0) ? 23 : $urandom_range(0, 23),
                         ($urandom_range(0, 1) == 0) ? 59 : $urandom_range(0, 59),
                         ($urandom_range(0, 4) < 3) ? $urandom_range(50, 59)
                                                    : $urandom_range(0, 59),
                         $urandom_range(0, 6));
    endfunction

    // Idle for a random gap, then present the word and hold it until accepted.
    // Valid is left high on return so a zero gap keeps it up without a glitch.
    task automatic send_word(input in_word_t w);
        int gap;
        if ($urandom_range(0, 39) == 0)
            feed_steady = !feed_steady;
        gap = feed_steady ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        stim_word <= w;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    // Drop valid, wait until every predicted result word has come back, then let
    // the two-stage pipe settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_floor_year(input logic [YEAR_W-1:0] value);
        wait_drained();
        min_year_we    <= 1'b1;
        min_year_wdata <= value;
        floor_year      = value;
        @(posedge clk);
        min_year_we    <= 1'b0;
    endtask

    // Receiver: stall for a random gap before each result word.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                drain_steady = !drain_steady;
            gap = drain_steady ? 0 : $urandom_range(0, 16);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    initial
    begin
        logic [YEAR_W-1:0] floor_plan[4];
        int                pick;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        min_year_we    = 1'b0;
        min_year_wdata = '0;
        stim_word      = '0;
        floor_year     = 14'd1900;
        feed_steady    = 1'b0;
        drain_steady   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset value of min_year.
        send_word(tick_word());                                // first tick after reset
        send_word(load_word(1899, 6, 15, 12, 0, 0, 3));        // year below min_year
        send_word(load_word(1900, 1, 1, 0, 0, 0, 1));          // year exactly min_year
        send_word(load_word(9999, 12, 31, 23, 59, 59, 6));
        send_word(tick_word());                                // year saturates, weekday wraps
        send_word(load_word(10000, 1, 1, 0, 0, 0, 0));         // year just above 9999
        send_word(load_word(16383, 15, 31, 31, 63, 63, 7));    // every field at its top
        send_word(load_word(2024, 2, 28, 23, 59, 59, 3));
        send_word(tick_word());                                // leap day
        send_word(load_word(2024, 2, 29, 23, 59, 59, 4));
        send_word(tick_word());                                // leap February ends
        send_word(load_word(2023, 2, 29, 8, 0, 0, 2));         // leap day in a common year
        send_word(load_word(2023, 2, 28, 23, 59, 59, 2));
        send_word(tick_word());                                // common February ends
        send_word(load_word(2023, 4, 31, 8, 0, 0, 2));         // day past a 30-day month
        send_word(load_word(2023, 4, 30, 23, 59, 59, 0));
        send_word(tick_word());                                // 30-day month ends
        send_word(load_word(2023, 12, 31, 23, 59, 59, 0));
        send_word(tick_word());                                // year carry
        send_word(load_word(2023, 0, 10, 8, 0, 0, 2));         // month zero
        send_word(load_word(2023, 13, 10, 8, 0, 0, 2));        // month past December
        send_word(load_word(2023, 5, 0, 8, 0, 0, 2));          // day zero
        send_word(load_word(2023, 5, 10, 24, 0, 0, 2));        // hour too large
        send_word(load_word(2023, 5, 10, 8, 60, 0, 2));        // minute too large
        send_word(load_word(2023, 5, 10, 8, 0, 60, 2));        // second too large
        send_word(load_word(2023, 5, 10, 8, 0, 0, 7));         // weekday too large

        // Random phases, each under its own min_year; the time carries over.
        floor_plan[0] = 14'd0;
        floor_plan[1] = 14'd9999;
        floor_plan[2] = YEAR_W'($urandom_range(9999, 0));
        floor_plan[3] = 14'd1900;
        foreach (floor_plan[p])
        begin
            set_floor_year(floor_plan[p]);
            repeat (PHASE_WORDS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_word(tick_word());
                else if (pick < 82)
                    send_word(boundary_load());
                else
                    send_word(noise_load());
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
